@@ rtl/bpc_pkg.sv @@
// Shared widths, constants, register indexes and types for the barometer compensation block.
package bpc_pkg;

    localparam int RAW_W     = 24;
    localparam int COEF_W    = 16;
    localparam int TEMP_W    = 15;
    localparam int PRES_W    = 17;
    localparam int CFG_IDX_W = 3;
    localparam int NSTG      = 10;

    localparam int TEMP_REF  = 2000;
    localparam int TEMP_VLOW = -1500;
    localparam int VLOW_OFS  = TEMP_REF - TEMP_VLOW;
    localparam int TEMP_MIN  = -4000;
    localparam int TEMP_MAX  = 8500;
    localparam int PRES_MIN  = 1000;
    localparam int PRES_MAX  = 120000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENS,
        CFG_OFF,
        CFG_TCS,
        CFG_TCO,
        CFG_TREF,
        CFG_TEMPSENS
    } t_cfg_idx;

    typedef struct packed {
        logic pp;
        logic sum;
    } t_mul_en;

endpackage

@@ rtl/bpc_raw_if.sv @@
// Channel that carries one raw pressure and temperature conversion pair.
interface bpc_raw_if import bpc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [RAW_W-1:0]  raw_pressure;
    logic [RAW_W-1:0]  raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

@@ rtl/bpc_comp_if.sv @@
// Channel that carries one compensated temperature and pressure result.
interface bpc_comp_if import bpc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temperature;
    logic [PRES_W-1:0]        pressure;
    logic                     clamped;

    modport source (output valid, output temperature, output pressure, output clamped,
                    input ready);
    modport sink   (input valid, input temperature, input pressure, input clamped,
                    output ready);
endinterface

@@ rtl/barometer_pressure_compensation.sv @@
// Top level of the barometer pressure and temperature compensation pipeline.
//
//   channel   direction  handshake        word
//   i_raw     in         valid / ready    raw_pressure, raw_temperature
//   o_comp    out        valid / ready    temperature, pressure, clamped
//   i_cfg_*   in         write enable     register index, 16-bit calibration data
//
// The datapath is a ten-stage pipeline that accepts one word per cycle while the output
// is not stalled; results are offered from the output register in the order accepted.
// Every stage has its own valid bit and moves when the stage after it is empty or
// moving, so a stalled output holds its result while bubbles upstream still fill.
// Synchronous reset empties the pipeline and clears the calibration registers.
module barometer_pressure_compensation import bpc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [COEF_W-1:0]     i_cfg_data,
    bpc_raw_if.sink               i_raw,
    bpc_comp_if.source            o_comp
);

    localparam logic signed [19:0]       T_LO     = 20'(TEMP_MIN);
    localparam logic signed [19:0]       T_HI     = 20'(TEMP_MAX);
    localparam logic signed [TEMP_W-1:0] T_OUT_LO = T_LO[TEMP_W-1:0];
    localparam logic signed [TEMP_W-1:0] T_OUT_HI = T_HI[TEMP_W-1:0];
    localparam logic signed [27:0]       P_LO     = 28'(PRES_MIN);
    localparam logic signed [27:0]       P_HI     = 28'(PRES_MAX);
    localparam logic [PRES_W-1:0]        P_OUT_LO = P_LO[PRES_W-1:0];
    localparam logic [PRES_W-1:0]        P_OUT_HI = P_HI[PRES_W-1:0];

    logic [COEF_W-1:0] r_coeff_sens;
    logic [COEF_W-1:0] r_coeff_off;
    logic [COEF_W-1:0] r_coeff_tcs;
    logic [COEF_W-1:0] r_coeff_tco;
    logic [COEF_W-1:0] r_coeff_tref;
    logic [COEF_W-1:0] r_coeff_tempsens;

    logic [NSTG:1] r_vld;
    logic [NSTG:1] vld_prev;
    logic [NSTG:1] en;
    t_mul_en       mul_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff_sens     <= '0;
            r_coeff_off      <= '0;
            r_coeff_tcs      <= '0;
            r_coeff_tco      <= '0;
            r_coeff_tref     <= '0;
            r_coeff_tempsens <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SENS:     r_coeff_sens     <= i_cfg_data;
                CFG_OFF:      r_coeff_off      <= i_cfg_data;
                CFG_TCS:      r_coeff_tcs      <= i_cfg_data;
                CFG_TCO:      r_coeff_tco      <= i_cfg_data;
                CFG_TREF:     r_coeff_tref     <= i_cfg_data;
                CFG_TEMPSENS: r_coeff_tempsens <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        en[NSTG] = !r_vld[NSTG] || o_comp.ready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        vld_prev[1] = i_raw.valid;
        for (int k = 2; k <= NSTG; k++) begin
            vld_prev[k] = r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= vld_prev[k];
                end
            end
        end
    end

    assign i_raw.ready = en[1];
    assign mul_en.pp   = en[7];
    assign mul_en.sum  = en[8];

    // Stage 1: temperature difference from the reference.
    logic [RAW_W-1:0]   r1_d1;
    logic signed [24:0] r1_dt;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_d1 <= i_raw.raw_pressure;
            r1_dt <= $signed({1'b0, i_raw.raw_temperature})
                   - $signed({1'b0, r_coeff_tref, 8'd0});
        end
    end

    // Stage 2: the four products of the temperature difference.
    logic signed [41:0] n2_mt;
    logic signed [41:0] n2_mo;
    logic signed [41:0] n2_ms;
    logic signed [49:0] n2_dd;
    logic [RAW_W-1:0]   r2_d1;
    logic signed [40:0] r2_mt;
    logic signed [40:0] r2_mo;
    logic signed [40:0] r2_ms;
    logic [47:0]        r2_dd;

    assign n2_mt = r1_dt * $signed({1'b0, r_coeff_tempsens});
    assign n2_mo = r1_dt * $signed({1'b0, r_coeff_tco});
    assign n2_ms = r1_dt * $signed({1'b0, r_coeff_tcs});
    assign n2_dd = r1_dt * r1_dt;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_d1 <= r1_d1;
            r2_mt <= n2_mt[40:0];
            r2_mo <= n2_mo[40:0];
            r2_ms <= n2_ms[40:0];
            r2_dd <= n2_dd[47:0];
        end
    end

    // Stage 3: first-order temperature, offset and sensitivity.
    logic signed [17:0] n3_a;
    logic signed [18:0] n3_temp;
    logic signed [18:0] n3_b;
    logic signed [34:0] n3_off;
    logic signed [33:0] n3_sens;
    logic [RAW_W-1:0]   r3_d1;
    logic signed [17:0] r3_a;
    logic signed [18:0] r3_b;
    logic signed [18:0] r3_temp;
    logic signed [34:0] r3_off;
    logic signed [33:0] r3_sens;
    logic [16:0]        r3_t2;
    logic               r3_low;
    logic               r3_vlow;

    assign n3_a    = r2_mt[40:23];
    assign n3_temp = $signed({n3_a[17], n3_a}) + $signed(19'(TEMP_REF));
    assign n3_b    = $signed({n3_a[17], n3_a}) + $signed(19'(VLOW_OFS));
    assign n3_off  = $signed({3'd0, r_coeff_off, 16'd0}) + $signed({r2_mo[40], r2_mo[40:7]});
    assign n3_sens = $signed({3'd0, r_coeff_sens, 15'd0}) + $signed({r2_ms[40], r2_ms[40:8]});

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_d1   <= r2_d1;
            r3_a    <= n3_a;
            r3_b    <= n3_b;
            r3_temp <= n3_temp;
            r3_off  <= n3_off;
            r3_sens <= n3_sens;
            r3_t2   <= r2_dd[47:31];
            r3_low  <= n3_a[17];
            r3_vlow <= n3_b[18];
        end
    end

    // Stage 4: squares for the low-temperature terms and the corrected temperature.
    logic signed [35:0] n4_asq;
    logic signed [37:0] n4_bsq;
    logic signed [19:0] n4_tf;
    logic [RAW_W-1:0]   r4_d1;
    logic [34:0]        r4_asq;
    logic [35:0]        r4_bsq;
    logic signed [19:0] r4_tf;
    logic signed [34:0] r4_off;
    logic signed [33:0] r4_sens;
    logic               r4_low;
    logic               r4_vlow;

    assign n4_asq = r3_a * r3_a;
    assign n4_bsq = r3_b * r3_b;
    assign n4_tf  = $signed({r3_temp[18], r3_temp})
                  - $signed(r3_low ? {3'd0, r3_t2} : 20'd0);

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_d1   <= r3_d1;
            r4_asq  <= n4_asq[34:0];
            r4_bsq  <= n4_bsq[35:0];
            r4_tf   <= n4_tf;
            r4_off  <= r3_off;
            r4_sens <= r3_sens;
            r4_low  <= r3_low;
            r4_vlow <= r3_vlow;
        end
    end

    // Stage 5: second-order offset and sensitivity terms, temperature limits.
    logic [36:0]              n5_a5;
    logic [38:0]              n5_b7;
    logic [39:0]              n5_b11;
    logic [37:0]              n5_off2;
    logic [36:0]              n5_sens2;
    logic signed [TEMP_W-1:0] n5_temp;
    logic                     n5_tclamp;
    logic [RAW_W-1:0]         r5_d1;
    logic [37:0]              r5_off2;
    logic [36:0]              r5_sens2;
    logic signed [34:0]       r5_off;
    logic signed [33:0]       r5_sens;
    logic                     r5_low;
    logic signed [TEMP_W-1:0] r5_temp;
    logic                     r5_tclamp;

    assign n5_a5    = {r4_asq, 2'd0} + {2'd0, r4_asq};
    assign n5_b7    = {r4_bsq, 3'd0} - {3'd0, r4_bsq};
    assign n5_b11   = {1'b0, r4_bsq, 3'd0} + {3'd0, r4_bsq, 1'b0} + {4'd0, r4_bsq};
    assign n5_off2  = {2'd0, n5_a5[36:1]} + (r4_vlow ? n5_b7[37:0] : 38'd0);
    assign n5_sens2 = {2'd0, n5_a5[36:2]} + (r4_vlow ? n5_b11[37:1] : 37'd0);

    always_comb begin
        n5_tclamp = 1'b0;
        n5_temp   = r4_tf[TEMP_W-1:0];
        if (r4_tf < T_LO) begin
            n5_temp   = T_OUT_LO;
            n5_tclamp = 1'b1;
        end else if (r4_tf > T_HI) begin
            n5_temp   = T_OUT_HI;
            n5_tclamp = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_d1     <= r4_d1;
            r5_off2   <= n5_off2;
            r5_sens2  <= n5_sens2;
            r5_off    <= r4_off;
            r5_sens   <= r4_sens;
            r5_low    <= r4_low;
            r5_temp   <= n5_temp;
            r5_tclamp <= n5_tclamp;
        end
    end

    // Stage 6: apply the second-order corrections.
    logic [RAW_W-1:0]         r6_d1;
    logic signed [39:0]       r6_offc;
    logic signed [38:0]       r6_sensc;
    logic signed [TEMP_W-1:0] r6_temp;
    logic                     r6_tclamp;

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r6_d1     <= r5_d1;
            r6_offc   <= $signed({{5{r5_off[34]}}, r5_off})
                       - $signed(r5_low ? {2'd0, r5_off2} : 40'd0);
            r6_sensc  <= $signed({{5{r5_sens[33]}}, r5_sens})
                       - $signed(r5_low ? {2'd0, r5_sens2} : 39'd0);
            r6_temp   <= r5_temp;
            r6_tclamp <= r5_tclamp;
        end
    end

    // Stages 7 and 8: raw pressure times sensitivity.
    logic signed [62:0]       mul_p;
    logic signed [39:0]       r7_offc;
    logic signed [TEMP_W-1:0] r7_temp;
    logic                     r7_tclamp;
    logic signed [39:0]       r8_offc;
    logic signed [TEMP_W-1:0] r8_temp;
    logic                     r8_tclamp;

    bpc_wide_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (r6_d1),
        .i_b   (r6_sensc),
        .o_p   (mul_p)
    );

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r7_offc   <= r6_offc;
            r7_temp   <= r6_temp;
            r7_tclamp <= r6_tclamp;
        end
        if (en[8]) begin
            r8_offc   <= r7_offc;
            r8_temp   <= r7_temp;
            r8_tclamp <= r7_tclamp;
        end
    end

    // Stage 9: scaled product minus offset.
    logic signed [42:0]       r9_q;
    logic signed [TEMP_W-1:0] r9_temp;
    logic                     r9_tclamp;

    always_ff @(posedge i_clk) begin
        if (en[9]) begin
            r9_q      <= $signed({mul_p[62], mul_p[62:21]})
                       - $signed({{3{r8_offc[39]}}, r8_offc});
            r9_temp   <= r8_temp;
            r9_tclamp <= r8_tclamp;
        end
    end

    // Stage 10: pressure limits and the output register.
    logic signed [27:0]       n10_p;
    logic [PRES_W-1:0]        n10_pres;
    logic                     n10_pclamp;
    logic [PRES_W-1:0]        r10_pres;
    logic signed [TEMP_W-1:0] r10_temp;
    logic                     r10_clamp;

    assign n10_p = r9_q[42:15];

    always_comb begin
        n10_pclamp = 1'b0;
        n10_pres   = n10_p[PRES_W-1:0];
        if (n10_p < P_LO) begin
            n10_pres   = P_OUT_LO;
            n10_pclamp = 1'b1;
        end else if (n10_p > P_HI) begin
            n10_pres   = P_OUT_HI;
            n10_pclamp = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[10]) begin
            r10_pres  <= n10_pres;
            r10_temp  <= r9_temp;
            r10_clamp <= r9_tclamp || n10_pclamp;
        end
    end

    assign o_comp.valid       = r_vld[NSTG];
    assign o_comp.temperature = r10_temp;
    assign o_comp.pressure    = r10_pres;
    assign o_comp.clamped     = r10_clamp;

`ifndef SYNTHESIS
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> r_vld == '0)
        else $error("Pipeline not empty after reset.");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_raw.ready |-> &r_vld)
        else $error("Input stalled while a pipeline stage is empty.");

    a_temp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_comp.valid |-> (o_comp.temperature >= T_OUT_LO && o_comp.temperature <= T_OUT_HI))
        else $error("Output temperature outside its rated range.");

    a_pres_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_comp.valid |-> (o_comp.pressure >= P_OUT_LO && o_comp.pressure <= P_OUT_HI))
        else $error("Output pressure outside its rated range.");
`endif

endmodule

@@ rtl/bpc_wide_mul.sv @@
// Two-stage 24 by 39 bit signed multiplier built from two narrower partial products.
module bpc_wide_mul import bpc_pkg::*; (
    input  logic                     i_clk,
    input  t_mul_en                  i_en,
    input  logic [RAW_W-1:0]         i_a,
    input  logic signed [38:0]       i_b,
    output logic signed [62:0]       o_p
);

    logic [43:0]        n_lo;
    logic signed [43:0] n_hi;
    logic [43:0]        r_lo;
    logic signed [42:0] r_hi;
    logic signed [62:0] n_p;
    logic signed [62:0] r_p;

    assign n_lo = i_a * i_b[19:0];
    assign n_hi = $signed({1'b0, i_a}) * $signed(i_b[38:20]);
    assign n_p  = $signed({r_hi, 20'd0}) + $signed({19'd0, r_lo});

    always_ff @(posedge i_clk) begin
        if (i_en.pp) begin
            r_lo <= n_lo;
            r_hi <= n_hi[42:0];
        end
        if (i_en.sum) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

@@ sim/bpc_comp_checker.sv @@
// Checker that predicts each compensated word from the raw words and the calibration writes it sees.
module bpc_comp_checker import bpc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COEF_W-1:0]    i_cfg_data,
    bpc_raw_if                   i_raw,
    bpc_comp_if                  i_comp,
    output int                   o_mismatches,
    output int                   o_outstanding
);

    localparam int NREG = CFG_TEMPSENS + 1;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic [PRES_W-1:0]        pressure;
        logic                     clamped;
    } t_reading;

    logic [COEF_W-1:0] cal [NREG];
    t_reading          readings_due [$];
    int                mismatches = 0;

    // Every shift of a signed value below is a floor division by a power of two.
    function automatic t_reading compensate(input logic [RAW_W-1:0] d1_raw,
                                            input logic [RAW_W-1:0] d2_raw);
        longint   d1, dt, temp, off, sens, t2, off2, sens2, dev, vdev, p;
        t_reading r;
        d1    = longint'(d1_raw);
        dt    = longint'(d2_raw) - longint'(cal[CFG_TREF]) * 256;
        temp  = TEMP_REF + ((dt * longint'(cal[CFG_TEMPSENS])) >>> 23);
        off   = longint'(cal[CFG_OFF]) * 65536 + ((longint'(cal[CFG_TCO]) * dt) >>> 7);
        sens  = longint'(cal[CFG_SENS]) * 32768 + ((longint'(cal[CFG_TCS]) * dt) >>> 8);
        t2    = 0;
        off2  = 0;
        sens2 = 0;
        if (temp < TEMP_REF) begin
            dev   = temp - TEMP_REF;
            t2    = (dt * dt) >>> 31;
            off2  = (5 * dev * dev) >>> 1;
            sens2 = (5 * dev * dev) >>> 2;
            if (temp < TEMP_VLOW) begin
                vdev  = temp - TEMP_VLOW;
                off2  = off2 + 7 * vdev * vdev;
                sens2 = sens2 + ((11 * vdev * vdev) >>> 1);
            end
        end
        temp = temp - t2;
        p    = (((d1 * (sens - sens2)) >>> 21) - (off - off2)) >>> 15;
        r.clamped = 1'b0;
        if (temp < TEMP_MIN) begin
            temp = TEMP_MIN;
            r.clamped = 1'b1;
        end
        if (temp > TEMP_MAX) begin
            temp = TEMP_MAX;
            r.clamped = 1'b1;
        end
        if (p < PRES_MIN) begin
            p = PRES_MIN;
            r.clamped = 1'b1;
        end
        if (p > PRES_MAX) begin
            p = PRES_MAX;
            r.clamped = 1'b1;
        end
        r.temperature = TEMP_W'(temp);
        r.pressure    = PRES_W'(p);
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_reading want;
        t_reading got;
        if (!i_rst_n) begin
            foreach (cal[i]) cal[i] = '0;
            readings_due.delete();
        end else begin
            if (i_raw.valid && i_raw.ready) begin
                readings_due.push_back(compensate(i_raw.raw_pressure, i_raw.raw_temperature));
            end
            if (i_comp.valid && i_comp.ready) begin
                got.temperature = i_comp.temperature;
                got.pressure    = i_comp.pressure;
                got.clamped     = i_comp.clamped;
                if (readings_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected word: temperature %0d pressure %0d clamped %b",
                                 got.temperature, got.pressure, got.clamped);
                    end
                end else begin
                    want = readings_due.pop_front();
                    if (got.temperature !== want.temperature || got.pressure !== want.pressure
                            || got.clamped !== want.clamped) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: temperature %0d/%0d pressure %0d/%0d clamped %b/%b",
                                     want.temperature, got.temperature, want.pressure,
                                     got.pressure, want.clamped, got.clamped);
                        end
                    end
                end
            end
            if (i_cfg_we && i_cfg_idx < NREG) begin
                cal[i_cfg_idx] = i_cfg_data;
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= readings_due.size();
    end

endmodule

@@ sim/testbench.sv @@
// Top of the simulation: clock, reset, calibration writes, raw words and the pass or fail verdict.
module testbench;
    import bpc_pkg::*;

    localparam int NREG            = CFG_TEMPSENS + 1;
    localparam int NPHASE          = 8;
    localparam int ITEMS_PER_PHASE = 48;
    localparam int LAST_CYCLE      = 400000;
    localparam logic [RAW_W-1:0]     RAW_MAX    = {RAW_W{1'b1}};
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(CFG_TEMPSENS + 1);

    typedef logic [COEF_W-1:0] t_cal_set [NREG];
    typedef enum int {RX_FREE, RX_HALF, RX_MOSTLY, RX_CHOKED} t_rx_mode;
    typedef enum int {CAL_TYPICAL, CAL_RANDOM, CAL_EXTREME} t_cal_kind;

    localparam t_cal_set TYPICAL_CAL = '{16'd40127, 16'd36924, 16'd23317,
                                         16'd23282, 16'd33464, 16'd28312};

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [COEF_W-1:0]    cfg_data;
    int                   mismatches;
    int                   outstanding;
    int                   cycle_count = 0;

    bpc_raw_if  raw_ch ();
    bpc_comp_if comp_ch ();

    barometer_pressure_compensation u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_raw      (raw_ch),
        .o_comp     (comp_ch)
    );

    bpc_comp_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_raw         (raw_ch),
        .i_comp        (comp_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LAST_CYCLE) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // All tasks are entered and left at a falling edge.
    task automatic send_word(input logic [RAW_W-1:0] pres, input logic [RAW_W-1:0] temp);
        raw_ch.valid           <= 1'b1;
        raw_ch.raw_pressure    <= pres;
        raw_ch.raw_temperature <= temp;
        @(posedge clk);
        while (!raw_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic idle_for(input int cycles);
        if (cycles > 0) raw_ch.valid <= 1'b0;
        repeat (cycles) begin
            raw_ch.raw_pressure    <= RAW_W'($urandom);
            raw_ch.raw_temperature <= RAW_W'($urandom);
            @(negedge clk);
        end
    endtask

    task automatic wait_idle();
        raw_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (NSTG) @(negedge clk);
    endtask

    task automatic load_calibration(input t_cal_set cs);
        wait_idle();
        for (int i = 0; i < NREG; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= i[CFG_IDX_W-1:0];
            cfg_data <= cs[i];
            @(negedge clk);
        end
        // A write to an unused index must leave the calibration alone.
        cfg_idx  <= CFG_IDX_W'($urandom_range(CFG_UNUSED, 2 ** CFG_IDX_W - 1));
        cfg_data <= COEF_W'($urandom);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin : receiver
        t_rx_mode mode;
        int       span;
        comp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            mode = t_rx_mode'($urandom_range(RX_FREE, RX_CHOKED));
            span = $urandom_range(16, 160);
            repeat (span) begin
                case (mode)
                    RX_FREE:   comp_ch.ready <= 1'b1;
                    RX_HALF:   comp_ch.ready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY: comp_ch.ready <= ($urandom_range(0, 7) != 0);
                    default:   comp_ch.ready <= ($urandom_range(0, 15) == 0);
                endcase
                @(negedge clk);
            end
        end
    end

    initial begin : stimulus
        t_cal_set  cs;
        t_cal_kind kind;
        int        burst_left;
        int        t_off;
        longint    t_raw;
        logic [RAW_W-1:0] p_raw;
        raw_ch.valid           = 1'b0;
        raw_ch.raw_pressure    = '0;
        raw_ch.raw_temperature = '0;
        cfg_we   = 1'b0;
        cfg_idx  = '0;
        cfg_data = '0;
        burst_left = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Calibration still at its reset value.
        send_word('0, '0);
        send_word(RAW_MAX, RAW_MAX);
        send_word(24'd9085466, 24'd8569150);

        load_calibration(TYPICAL_CAL);
        send_word(24'd9085466, 24'd8569150);
        send_word(24'd9085466, 24'd8566784);
        send_word(24'd9085466, 24'd8566783);
        send_word(24'd9085466, 24'd8270784);
        send_word(24'd9085466, 24'd7382784);
        send_word(24'd8000000, 24'd7800000);
        send_word(24'd9085466, 24'd9500000);
        send_word(24'd9085466, RAW_MAX);
        send_word(24'd9085466, '0);
        send_word('0, 24'd8569150);
        send_word(RAW_MAX, 24'd8569150);
        send_word(24'd4000000, 24'd8569150);

        foreach (cs[i]) cs[i] = '1;
        load_calibration(cs);
        send_word('0, '0);
        send_word(RAW_MAX, RAW_MAX);
        send_word(RAW_MAX, '0);
        send_word('0, RAW_MAX);

        for (int phase = 0; phase < NPHASE; phase++) begin
            if (phase <= CAL_EXTREME) begin
                kind = t_cal_kind'(phase);
            end else begin
                kind = t_cal_kind'($urandom_range(CAL_TYPICAL, CAL_EXTREME));
            end
            foreach (cs[i]) begin
                case (kind)
                    CAL_TYPICAL: cs[i] = COEF_W'(TYPICAL_CAL[i] + $urandom_range(0, 6000)
                                                 - 3000);
                    CAL_RANDOM:  cs[i] = COEF_W'($urandom);
                    default:     cs[i] = $urandom_range(0, 1) ? '1 : '0;
                endcase
            end
            load_calibration(cs);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (burst_left == 0) begin
                    idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
                    burst_left = $urandom_range(1, 24);
                end
                burst_left--;
                if ($urandom_range(0, 3) != 0) begin
                    // Plausible readings spread around the reference temperature.
                    t_off = $urandom_range(0, 2 ** 22) - 2 ** 21;
                    t_raw = longint'(cs[CFG_TREF]) * 256 + t_off;
                    if (t_raw < 0) t_raw = 0;
                    if (t_raw > longint'(RAW_MAX)) t_raw = longint'(RAW_MAX);
                    p_raw = RAW_W'($urandom_range(4000000, 12000000));
                    send_word(p_raw, RAW_W'(t_raw));
                end else begin
                    send_word(RAW_W'($urandom), RAW_W'($urandom));
                end
                if (phase == 3 && n == ITEMS_PER_PHASE / 2) wait_idle();
            end
        end

        wait_idle();
        if (mismatches == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/bpc_pkg.sv
rtl/bpc_raw_if.sv
rtl/bpc_comp_if.sv
rtl/bpc_wide_mul.sv
rtl/barometer_pressure_compensation.sv
sim/bpc_comp_checker.sv
sim/testbench.sv
